[rtl/ckv_pkg.sv]
`default_nettype none

package ckv_pkg;

  localparam int CMD_W     = 2;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int STATUS_W  = 3;
  localparam int TOTAL_W   = 8;
  localparam int DEPTH_DEF = 128;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

  // per-cell control
  typedef struct packed {
    logic load;    // take the broadcast pair
    logic shift;   // take the upper neighbor's pair
    logic active;  // cell holds a valid entry
  } cell_ctrl_t;

  // broadcast bus to all cells
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_bus_t;

endpackage

`default_nettype wire

[rtl/ckv_cell.sv]
`default_nettype none

module ckv_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire ckv_pkg::cell_ctrl_t  ctrl,
  input  wire ckv_pkg::cell_bus_t   bus,
  input  wire [ckv_pkg::KEY_W-1:0]  nb_key,
  input  wire [ckv_pkg::VAL_W-1:0]  nb_value,
  output logic [ckv_pkg::KEY_W-1:0] cur_key,
  output logic [ckv_pkg::VAL_W-1:0] cur_value,
  output logic                      match
);
  import ckv_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             match_r;

  // stored pair: insert load, or compaction from the neighbor above
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r   <= bus.key;
      value_r <= bus.value;
    end else if (ctrl.shift) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= ctrl.active && (key_r == bus.key);
    end
  end

  assign cur_key   = key_r;
  assign cur_value = value_r;
  assign match     = match_r;

endmodule

`default_nettype wire

[rtl/ckv_prefix.sv]
`default_nettype none

module ckv_prefix #(
  parameter int N = ckv_pkg::DEPTH_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire  [N-1:0]  match,
  output logic [N-1:0]  first,
  output logic [N-1:0]  upto,
  output logic          any
);
  import ckv_pkg::*;

  localparam int STEPS = $clog2(N);

  logic [N-1:0] pre [STEPS+1];
  logic [N-1:0] first_r;
  logic [N-1:0] upto_r;

  // log-depth prefix OR: bit i = OR of match[0..i]
  always_comb begin
    pre[0] = match;
    for (int s = 0; s < STEPS; s++) begin
      pre[s+1] = pre[s] | (pre[s] << (1 << s));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      upto_r  <= '0;
    end else begin
      first_r <= match & ~(pre[STEPS] << 1);
      upto_r  <= pre[STEPS];
    end
  end

  assign first = first_r;
  assign upto  = upto_r;
  assign any   = upto_r[N-1];

endmodule

`default_nettype wire

[rtl/ckv_or_tree.sv]
`default_nettype none

module ckv_or_tree #(
  parameter int N = ckv_pkg::DEPTH_DEF
) (
  input  wire                       clk,
  input  wire  [N-1:0]              hit,
  input  wire  [ckv_pkg::VAL_W-1:0] values [N],
  output logic [ckv_pkg::VAL_W-1:0] root
);
  import ckv_pkg::*;

  // 4-ary tree, one register per level
  localparam int LEVELS = ($clog2(N) + 1) / 2;
  localparam int LEAVES = 4 ** LEVELS;
  localparam int INNER  = (LEAVES - 1) / 3;

  logic [VAL_W-1:0] leaf   [LEAVES];
  logic [VAL_W-1:0] node_r [INNER];
  logic [VAL_W-1:0] kid    [INNER][4];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < N) begin : g_real
      assign leaf[k] = hit[k] ? values[k] : '0;
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  for (genvar i = 0; i < INNER; i++) begin : g_node
    for (genvar c = 0; c < 4; c++) begin : g_kid
      localparam int CI = 4 * i + 1 + c;
      if (CI < INNER) begin : g_inner
        assign kid[i][c] = node_r[CI];
      end else begin : g_edge
        assign kid[i][c] = leaf[CI-INNER];
      end
    end
    always_ff @(posedge clk) begin
      node_r[i] <= kid[i][0] | kid[i][1] | kid[i][2] | kid[i][3];
    end
  end

  assign root = node_r[0];

endmodule

`default_nettype wire

[rtl/compacting_key_value_table.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_command, in_key, in_entry_value
// out_      output     out_valid/out_stall out_status, out_found_value, out_entry_total
//
// One transaction at a time: a command passes the match register, the prefix
// register and the L levels of the value tree, L = ceil(log4(TABLE_DEPTH)),
// before the finish step; the next command is taken only after that.
// Reset clears the entry count, not the cell contents; cells are never read until written,
// so no clearing pass is needed.
// in_stall is high while a transaction is in flight; a waiting result holds the
// finish step until out_stall drops, while the output register keeps its data.

module compacting_key_value_table #(
  parameter int TABLE_DEPTH = ckv_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [ckv_pkg::CMD_W-1:0]    in_command,
  input  wire  [ckv_pkg::KEY_W-1:0]    in_key,
  input  wire  [ckv_pkg::VAL_W-1:0]    in_entry_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [ckv_pkg::STATUS_W-1:0] out_status,
  output logic [ckv_pkg::VAL_W-1:0]    out_found_value,
  output logic [ckv_pkg::TOTAL_W-1:0]  out_entry_total
);
  import ckv_pkg::*;

  localparam int N      = TABLE_DEPTH;
  localparam int CW     = $clog2(N + 1);
  localparam int LEVELS = ($clog2(N) + 1) / 2;
  localparam int WAIT   = LEVELS + 1;          // sized to cover the match, prefix and tree registers
  localparam int WW     = $clog2(WAIT + 1);

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_FINISH} state_t;

  state_t              state_r;
  logic [WW-1:0]       wait_r;
  logic [CW-1:0]       count_r;
  logic [CMD_W-1:0]    cmd_r;
  cell_bus_t           bus_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_found_value_r;
  logic [TOTAL_W-1:0]  out_entry_total_r;

  // cell row
  cell_ctrl_t          ctrl [N];
  logic [KEY_W-1:0]    cell_key   [N];
  logic [VAL_W-1:0]    cell_value [N];
  logic [N-1:0]        match_vec;
  logic [N-1:0]        hit_vec;
  logic [N-1:0]        upto_vec;
  logic                any_hit;
  logic [VAL_W-1:0]    tree_root;

  // finish step decode
  logic                in_fire;
  logic                out_fire;
  logic                fin_fire;
  logic                do_insert;
  logic                do_delete;
  logic [STATUS_W-1:0] status_nxt;
  logic [VAL_W-1:0]    found_nxt;
  logic [CW-1:0]       count_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  // finish only when the output register is free or being emptied
  assign fin_fire  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    status_nxt = ST_NOT_FOUND;
    found_nxt  = '0;
    count_nxt  = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (count_r < CW'(N)) begin
          do_insert  = 1'b1;
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_INSERTED;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        if (count_r == '0) begin
          status_nxt = ST_NO_DATA;
        end else if (!any_hit) begin
          status_nxt = ST_NOT_FOUND;
        end else if (cmd_r == CMD_SEARCH) begin
          status_nxt = ST_FOUND;
          found_nxt  = tree_root;
        end else begin
          do_delete  = 1'b1;
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_DELETED;
        end
      end
      default: begin
        status_nxt = ST_NOT_FOUND;  // reserved command: no change
      end
    endcase
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      wait_r            <= '0;
      count_r           <= '0;
      out_valid_r       <= 1'b0;
      out_status_r      <= '0;
      out_found_value_r <= '0;
      out_entry_total_r <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_WAIT;
            wait_r  <= WW'(WAIT);
          end
        end
        S_WAIT: begin
          if (wait_r == '0) begin
            state_r <= S_FINISH;
          end else begin
            wait_r <= wait_r - WW'(1);
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            state_r           <= S_IDLE;
            count_r           <= count_nxt;
            out_status_r      <= status_nxt;
            out_found_value_r <= found_nxt;
            out_entry_total_r <= TOTAL_W'(count_nxt);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // broadcast command and pair, held for the whole transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_command;
      bus_r.key   <= in_key;
      bus_r.value <= in_entry_value;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [KEY_W-1:0] nb_key;
    logic [VAL_W-1:0] nb_value;

    // append lands in the cell at the current count
    assign ctrl[i].load   = fin_fire && do_insert && (CW'(i) == count_r);
    // every cell at or above the first hit takes its upper neighbor
    assign ctrl[i].shift  = fin_fire && do_delete && upto_vec[i];
    assign ctrl[i].active = (CW'(i) < count_r);

    if (i < N - 1) begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_value = cell_value[i+1];
    end else begin : g_top
      // last cell: whatever it takes falls outside the count
      assign nb_key   = cell_key[i];
      assign nb_value = cell_value[i];
    end

    ckv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[i]),
      .bus       (bus_r),
      .nb_key    (nb_key),
      .nb_value  (nb_value),
      .cur_key   (cell_key[i]),
      .cur_value (cell_value[i]),
      .match     (match_vec[i])
    );
  end

  ckv_prefix #(
    .N (N)
  ) u_prefix (
    .clk   (clk),
    .rst_n (rst_n),
    .match (match_vec),
    .first (hit_vec),
    .upto  (upto_vec),
    .any   (any_hit)
  );

  ckv_or_tree #(
    .N (N)
  ) u_tree (
    .clk    (clk),
    .hit    (hit_vec),
    .values (cell_value),
    .root   (tree_root)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_value_r;
  assign out_entry_total = out_entry_total_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("entry count above depth");

  a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one first hit");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && do_delete |=> count_r == $past(count_r) - CW'(1))
    else $error("delete did not lower the count");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside the finish step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> !ctrl[0].load && !ctrl[0].shift)
    else $error("cell written while the table is still matching");
`endif

endmodule

`default_nettype wire

[verif/ckv_table_checker.sv]
`default_nettype none

module ckv_table_checker #(
  parameter int TABLE_DEPTH = ckv_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire  [ckv_pkg::CMD_W-1:0]    in_command,
  input  wire  [ckv_pkg::KEY_W-1:0]    in_key,
  input  wire  [ckv_pkg::VAL_W-1:0]    in_entry_value,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire  [ckv_pkg::STATUS_W-1:0] out_status,
  input  wire  [ckv_pkg::VAL_W-1:0]    out_found_value,
  input  wire  [ckv_pkg::TOTAL_W-1:0]  out_entry_total,
  output int                           fail_count,
  output int                           replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ckv_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [TOTAL_W-1:0]  entry_total;
  } kv_reply_t;

  logic [KEY_W-1:0] shadow_keys   [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_values [TABLE_DEPTH];
  int unsigned      shadow_fill;
  kv_reply_t        replies_due [$];
  int               mismatches;

  // Table behavior: only cells below shadow_fill are ever read.
  function automatic kv_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] value);
    kv_reply_t r;
    int        hit;
    r.status      = ST_NOT_FOUND;
    r.found_value = '0;
    hit = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_keys[i] == key) hit = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (shadow_fill < TABLE_DEPTH) begin
          shadow_keys[shadow_fill]   = key;
          shadow_values[shadow_fill] = value;
          shadow_fill++;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        if (shadow_fill == 0) begin
          r.status = ST_NO_DATA;
        end else if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (cmd == CMD_SEARCH) begin
          r.status      = ST_FOUND;
          r.found_value = shadow_values[hit];
        end else begin
          for (int j = hit; j + 1 < shadow_fill; j++) begin
            shadow_keys[j]   = shadow_keys[j+1];
            shadow_values[j] = shadow_values[j+1];
          end
          shadow_fill--;
          r.status = ST_DELETED;
        end
      end
      default: ;  // reserved code: no change
    endcase
    r.entry_total = TOTAL_W'(shadow_fill);
    return r;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin : watch
    kv_reply_t due;
    if (!rst_n) begin
      shadow_fill = 0;
      replies_due.delete();
    end else begin
      // result side first so the oldest expectation is matched
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result transaction: status %0d", out_status);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (out_status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_status);
            mismatches++;
          end
          if (out_found_value !== due.found_value) begin
            $error("found_value: expected %h, actual %h", due.found_value, out_found_value);
            mismatches++;
          end
          if (out_entry_total !== due.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", due.entry_total,
                   out_entry_total);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(apply_command(in_command, in_key, in_entry_value));
    end
    fail_count      <= mismatches;
    replies_pending <= replies_due.size();
  end

endmodule

`default_nettype wire

[verif/tb_compacting_key_value_table.sv]
`default_nettype none

module tb_compacting_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ckv_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // the one code point the block does not define
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  // random part: fill toward full, drain, then a balanced mix
  localparam int FILL_ITEMS  = 180;
  localparam int DRAIN_ITEMS = 140;
  localparam int MIX_ITEMS   = 80;
  localparam int QUIET_ITEMS = 60;   // tail of the mix with no idling
  localparam int POOL_SIZE   = 12;

  // input gaps and result stalls are bounded, so reaching
  // IDLE_LIMIT idle cycles means the block is stuck
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 24;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  wire                 in_stall;
  logic [CMD_W-1:0]    in_command = CMD_INSERT;
  logic [KEY_W-1:0]    in_key = '0;
  logic [VAL_W-1:0]    in_entry_value = '0;
  wire                 out_valid;
  logic                out_stall = 1'b0;
  wire  [STATUS_W-1:0] out_status;
  wire  [VAL_W-1:0]    out_found_value;
  wire  [TOTAL_W-1:0]  out_entry_total;

  int   fail_count;
  int   replies_pending;
  int   idle_cycles = 0;
  logic quiet = 1'b0;     // no idling on either side when set

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  compacting_key_value_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_total (out_entry_total)
  );

  ckv_table_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_total (out_entry_total),
    .fail_count      (fail_count),
    .replies_pending (replies_pending)
  );

  // Watchdog: any cycle with no transaction on either channel counts.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("compacting_key_value_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, off in the tail.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && !quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one transaction, hold it through in_stall, then maybe idle.
  // Called and returns at a rising edge; valid is only lowered for a gap,
  // so back-to-back items never see a low and a high in one step.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key         <= key;
    in_entry_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  // Mostly pool keys so deletes and searches hit, duplicates included;
  // the rest are fresh keys that almost surely miss.
  task automatic send_random(input int insert_pct, input int delete_pct);
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct)                   cmd = CMD_INSERT;
    else if (roll < insert_pct + delete_pct) cmd = CMD_DELETE;
    else if (roll < 97)                      cmd = CMD_SEARCH;
    else                                     cmd = CMD_RESERVED;
    if ($urandom_range(0, 7) == 0) key = {$urandom, $urandom};
    else                           key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_item(cmd, key, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] dup_key;
    logic [KEY_W-1:0] miss_key;
    logic [VAL_W-1:0] first_val;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {1'b1, {(KEY_W-2){1'b0}}, 1'b1};
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    dup_key   = 64'h0123_4567_89ab_cdef;
    miss_key  = 64'hfeed_0000_0000_beef;
    first_val = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table answers, reserved code, extremes of key and
    // value, duplicate keys, misses, delete at the head and the middle,
    // and emptying the table again.
    send_item(CMD_SEARCH,   '0,       '0);
    send_item(CMD_DELETE,   '1,       '1);
    send_item(CMD_RESERVED, dup_key,  '1);
    send_item(CMD_INSERT,   '0,       '1);
    send_item(CMD_INSERT,   '1,       '0);
    send_item(CMD_INSERT,   dup_key,  first_val);
    send_item(CMD_INSERT,   dup_key,  ~first_val);
    send_item(CMD_SEARCH,   dup_key,  '0);
    send_item(CMD_SEARCH,   '1,       '0);
    send_item(CMD_SEARCH,   '0,       '1);
    send_item(CMD_SEARCH,   miss_key, '0);
    send_item(CMD_DELETE,   miss_key, '0);
    send_item(CMD_RESERVED, dup_key,  '0);
    send_item(CMD_DELETE,   dup_key,  '0);
    send_item(CMD_SEARCH,   dup_key,  '0);
    send_item(CMD_DELETE,   '0,       '0);
    send_item(CMD_SEARCH,   '1,       '0);
    send_item(CMD_DELETE,   dup_key,  '0);
    send_item(CMD_DELETE,   '1,       '0);
    send_item(CMD_SEARCH,   '1,       '1);
    pause_until_drained();

    // Fill: insert-heavy, runs into the full table and stays there a while.
    for (int n = 0; n < FILL_ITEMS; n++) send_random(90, 4);
    pause_until_drained();

    // Drain: delete-heavy, shifting the entries of a deep table.
    for (int n = 0; n < DRAIN_ITEMS; n++) send_random(12, 75);
    pause_until_drained();

    // Mix: balanced, with the last stretch at full rate on both sides.
    for (int n = 0; n < MIX_ITEMS; n++) begin
      if (n == MIX_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_random(40, 30);
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && replies_pending == 0) begin
      $display("compacting_key_value_table regression: pass");
    end else begin
      $display("compacting_key_value_table regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/ckv_pkg.sv
rtl/ckv_cell.sv
rtl/ckv_prefix.sv
rtl/ckv_or_tree.sv
rtl/compacting_key_value_table.sv
verif/ckv_table_checker.sv
verif/tb_compacting_key_value_table.sv
